/* sv/life_generation_stream_core_macros.svh */
// Assertion macros shared by the life generation stream RTL.
// Each macro expects clock aclk and active-low reset aresetn in scope.
`ifndef LIFE_GENERATION_STREAM_CORE_MACROS_SVH
`define LIFE_GENERATION_STREAM_CORE_MACROS_SVH

// Property checked on every clock edge outside reset.
`define LGS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define LGS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/lgs_pkg.sv */
// Shared types, constants and the B3/S23 cell rule for the life generation stream.
// No dependencies.
package lgs_pkg;

    localparam int MAX_WIDTH    = 32;
    localparam int MAX_HEIGHT   = 1024;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(MAX_HEIGHT);
    localparam int GW_REG_W     = 6;
    localparam int GH_REG_W     = 11;
    localparam int CFG_DATA_W   = 11;
    localparam int CFG_ADDR_W   = 2;
    localparam int S_TDATA_W    = 8;
    localparam int M_TDATA_W    = 16;
    localparam int COL_MEM_W    = 2;   // {two rows back, one row back}
    localparam int NUM_RES      = 4;

    localparam logic [GW_REG_W-1:0] GW_RESET = GW_REG_W'(32);
    localparam logic [GH_REG_W-1:0] GH_RESET = GH_REG_W'(32);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_GRID_WIDTH  = 2'd0,
        REG_GRID_HEIGHT = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [COL_W-1:0] out_col;
        logic [ROW_W-1:0] out_row;
        logic             next_alive;
    } cell_res_t;

    typedef struct packed {
        cell_res_t [NUM_RES-1:0] res;
        logic [NUM_RES-1:0]      mask;
        logic                    frame_end;
    } res_set_t;

    // mid[1] is the cell itself, the other eight bits are its neighbors
    function automatic logic life_cell(logic [2:0] top, logic [2:0] mid, logic [2:0] bot);
        logic [3:0] cnt;
        cnt = {3'b0, top[0]} + {3'b0, top[1]} + {3'b0, top[2]}
            + {3'b0, mid[0]} + {3'b0, mid[2]}
            + {3'b0, bot[0]} + {3'b0, bot[1]} + {3'b0, bot[2]};
        return mid[1] ? ((cnt == 4'd2) || (cnt == 4'd3)) : (cnt == 4'd3);
    endfunction

endpackage

/* sv/lgs_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Read-first on a same-address collision. No dependencies.
module lgs_ram #(
    parameter int DATA_W = 2,
    parameter int DEPTH  = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/lgs_window.sv */
// Window stage: column store read-modify-write, 3x3 window and result generation.
// Depends on lgs_pkg, lgs_ram and the assertion macro header.
`include "life_generation_stream_core_macros.svh"

module lgs_window (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      in_alive,
    input  logic [lgs_pkg::ROW_W-1:0] in_row,
    input  logic [lgs_pkg::COL_W-1:0] in_col,
    input  logic                      in_last_row,
    input  logic                      in_last_col,
    input  logic                      emit_free,
    output logic                      set_load,
    output lgs_pkg::res_set_t         set_out
);
    import lgs_pkg::*;

    logic                 s1_valid_reg;
    logic                 s1_alive_reg;
    logic [ROW_W-1:0]     s1_row_reg;
    logic [COL_W-1:0]     s1_col_reg;
    logic                 s1_last_row_reg;
    logic                 s1_last_col_reg;
    logic                 byp_reg;
    logic [COL_MEM_W-1:0] byp_data_reg;
    logic [2:0][2:0]      win_reg;
    logic [2:0][2:0]      win_next;

    logic                 s1_move;
    logic [COL_MEM_W-1:0] ram_rdata;
    logic [COL_MEM_W-1:0] mem_q;
    logic [COL_MEM_W-1:0] ram_wdata;
    logic                 up1;
    logic                 up2;
    logic [2:0]           up2_l;
    logic [2:0]           up1_l;
    logic [2:0]           now_l;
    logic [2:0]           up2_r;
    logic [2:0]           up1_r;
    logic [2:0]           now_r;
    logic                 row_nz;
    logic                 col_nz;

    assign s1_move  = s1_valid_reg && emit_free;
    assign in_ready = !s1_valid_reg || emit_free;
    assign set_load = s1_move;

    // column c holds {two rows back, one row back}; write the shifted pair back
    assign ram_wdata = {mem_q[0], s1_alive_reg};

    lgs_ram #(
        .DATA_W (COL_MEM_W),
        .DEPTH  (MAX_WIDTH)
    ) u_col_ram (
        .aclk    (aclk),
        .wr_en   (s1_move),
        .wr_addr (s1_col_reg),
        .wr_data (ram_wdata),
        .rd_en   (in_valid),
        .rd_addr (in_col),
        .rd_data (ram_rdata)
    );

    // forward a write that lands on the column being read in the same cycle
    assign mem_q  = byp_reg ? byp_data_reg : ram_rdata;
    assign row_nz = (s1_row_reg != '0);
    assign col_nz = (s1_col_reg != '0);
    assign up1    = row_nz && mem_q[0];
    assign up2    = (s1_row_reg[ROW_W-1:1] != '0) && mem_q[1];

    always_comb begin
        win_next[2] = {up2, up1, s1_alive_reg};
        win_next[1] = col_nz ? win_reg[2] : 3'b000;
        win_next[0] = col_nz ? win_reg[1] : 3'b000;
    end

    // columns c-2..c for the cell left of the input, c-1..c+1 for the last column
    always_comb begin
        up2_l = {win_next[2][2], win_next[1][2], win_next[0][2]};
        up1_l = {win_next[2][1], win_next[1][1], win_next[0][1]};
        now_l = {win_next[2][0], win_next[1][0], win_next[0][0]};
        up2_r = {1'b0, win_next[2][2], win_next[1][2]};
        up1_r = {1'b0, win_next[2][1], win_next[1][1]};
        now_r = {1'b0, win_next[2][0], win_next[1][0]};
    end

    always_comb begin
        set_out.res[0].next_alive = life_cell(up2_l, up1_l, now_l);
        set_out.res[0].out_row    = s1_row_reg - ROW_W'(1);
        set_out.res[0].out_col    = s1_col_reg - COL_W'(1);
        set_out.res[1].next_alive = life_cell(up1_l, now_l, 3'b000);
        set_out.res[1].out_row    = s1_row_reg;
        set_out.res[1].out_col    = s1_col_reg - COL_W'(1);
        set_out.res[2].next_alive = life_cell(up2_r, up1_r, now_r);
        set_out.res[2].out_row    = s1_row_reg - ROW_W'(1);
        set_out.res[2].out_col    = s1_col_reg;
        set_out.res[3].next_alive = life_cell(up1_r, now_r, 3'b000);
        set_out.res[3].out_row    = s1_row_reg;
        set_out.res[3].out_col    = s1_col_reg;
        set_out.mask[0]   = col_nz && row_nz;
        set_out.mask[1]   = col_nz && s1_last_row_reg;
        set_out.mask[2]   = s1_last_col_reg && row_nz;
        set_out.mask[3]   = s1_last_col_reg && s1_last_row_reg;
        set_out.frame_end = s1_last_col_reg && s1_last_row_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            byp_reg      <= 1'b0;
        end else begin
            if (in_valid) begin
                s1_valid_reg <= 1'b1;
                byp_reg      <= s1_move && (s1_col_reg == in_col);
            end else if (s1_move) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid) begin
            s1_alive_reg    <= in_alive;
            s1_row_reg      <= in_row;
            s1_col_reg      <= in_col;
            s1_last_row_reg <= in_last_row;
            s1_last_col_reg <= in_last_col;
            byp_data_reg    <= ram_wdata;
        end
        if (s1_move) begin
            win_reg <= win_next;
        end
    end

    `LGS_ASSERT_NEXT(a_stall_holds, s1_valid_reg && !emit_free, s1_valid_reg && $stable(s1_col_reg), "stalled item left the window stage")
    `LGS_ASSERT_NEXT(a_fwd_taken, in_valid && s1_move && (s1_col_reg == in_col), byp_reg, "same-column write not forwarded")

endmodule

/* sv/lgs_emit.sv */
// Result emitter: holds one item's results and sends one per cycle when m_tready.
// Depends on lgs_pkg and the assertion macro header.
`include "life_generation_stream_core_macros.svh"

module lgs_emit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          set_load,
    input  lgs_pkg::res_set_t             set_in,
    output logic                          emit_free,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lgs_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast
);
    import lgs_pkg::*;

    logic [NUM_RES-1:0]      mask_reg;
    logic [NUM_RES-1:0]      mask_next;
    cell_res_t [NUM_RES-1:0] res_reg;
    logic                    frame_end_reg;
    logic                    single;
    logic [1:0]              sel;
    cell_res_t               cur;

    assign single    = ((mask_reg & (mask_reg - NUM_RES'(1))) == '0);
    assign m_tvalid  = (mask_reg != '0);
    assign emit_free = !m_tvalid || (single && m_tready);

    always_comb begin
        priority if (mask_reg[0]) begin
            sel = 2'd0;
        end else if (mask_reg[1]) begin
            sel = 2'd1;
        end else if (mask_reg[2]) begin
            sel = 2'd2;
        end else begin
            sel = 2'd3;
        end
    end

    assign cur     = res_reg[sel];
    assign m_tdata = {cur.out_col, cur.out_row, cur.next_alive};
    assign m_tlast = m_tvalid && single && frame_end_reg;

    always_comb begin
        mask_next = mask_reg;
        if (set_load) begin
            mask_next = set_in.mask;
        end else if (m_tvalid && m_tready) begin
            // drop the lowest pending result
            mask_next = mask_reg & (mask_reg - NUM_RES'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
        end else begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (set_load) begin
            res_reg       <= set_in.res;
            frame_end_reg <= set_in.frame_end;
        end
    end

    `LGS_ASSERT(a_load_when_free, set_load |-> emit_free, "result set loaded over pending results")

endmodule

/* sv/life_generation_stream_core.sv */
// Top level of the life generation stream: configuration, position counters,
// window stage and result emitter. Uses lgs_pkg, lgs_window, lgs_emit, macro header.
//
// One B3/S23 Life step on a grid streamed row-major, one cell per item; cells
// outside the grid are dead. An input at (r,c) reports (r-1,c-1) once its
// neighborhood is complete; the last column and the last row add the cells
// that have no later neighbor, so one item yields 0 to 4 results and the final
// result of a frame carries tlast. Items are taken one per cycle as long as
// each yields at most one result and m_tready stays high; an item with more
// results holds the input until the emitter, one result per cycle while
// m_tready is high, is handing out its last one. A result passes the window
// stage register and then the emitter's result registers. The two previous
// rows live in a 32x2 column RAM read on accept and written back as the item
// passes to the emitter, with a forwarding path for single-column grids; it
// needs no clearing pass, as rows above the grid are masked by the row counter.
// A register write restarts the frame; write only while the block is idle.
`include "life_generation_stream_core_macros.svh"

module life_generation_stream_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lgs_pkg::S_TDATA_W-1:0]  s_tdata,   // [0] cell_alive
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [lgs_pkg::M_TDATA_W-1:0]  m_tdata,   // [0] next_alive, [10:1] out_row,
                                                      // [15:11] out_col
    output logic                           m_tlast,   // last_of_run
    input  logic                           cfg_wr_en,
    input  logic [lgs_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [lgs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import lgs_pkg::*;

    logic [GW_REG_W-1:0] width_reg;
    logic [GH_REG_W-1:0] height_reg;
    logic [COL_W-1:0]    col_count_reg;
    logic [ROW_W-1:0]    row_count_reg;
    logic [COL_W-1:0]    width_m1;
    logic [ROW_W-1:0]    height_m1;
    logic                last_col;
    logic                last_row;
    logic                accept;
    logic                cfg_hit;
    logic                emit_free;
    logic                set_load;
    res_set_t            set_bus;

    // clamp register values into the supported grid size
    always_comb begin
        priority if (width_reg == '0) begin
            width_m1 = '0;
        end else if (width_reg > GW_REG_W'(MAX_WIDTH)) begin
            width_m1 = COL_W'(MAX_WIDTH - 1);
        end else begin
            width_m1 = COL_W'(width_reg - GW_REG_W'(1));
        end
        priority if (height_reg == '0) begin
            height_m1 = '0;
        end else if (height_reg > GH_REG_W'(MAX_HEIGHT)) begin
            height_m1 = ROW_W'(MAX_HEIGHT - 1);
        end else begin
            height_m1 = ROW_W'(height_reg - GH_REG_W'(1));
        end
    end

    assign last_col = (col_count_reg == width_m1);
    assign last_row = (row_count_reg == height_m1);
    assign accept   = s_tvalid && s_tready;
    assign cfg_hit  = cfg_wr_en && ((cfg_addr == REG_GRID_WIDTH) ||
                                    (cfg_addr == REG_GRID_HEIGHT));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg     <= GW_RESET;
            height_reg    <= GH_RESET;
            col_count_reg <= '0;
            row_count_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_GRID_WIDTH: begin
                        width_reg <= cfg_wdata[GW_REG_W-1:0];
                    end
                    REG_GRID_HEIGHT: begin
                        height_reg <= cfg_wdata[GH_REG_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            // a register write restarts the frame
            priority if (cfg_hit) begin
                col_count_reg <= '0;
                row_count_reg <= '0;
            end else if (accept) begin
                if (last_col) begin
                    col_count_reg <= '0;
                    row_count_reg <= last_row ? '0 : row_count_reg + ROW_W'(1);
                end else begin
                    col_count_reg <= col_count_reg + COL_W'(1);
                end
            end
        end
    end

    lgs_window u_window (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (accept),
        .in_ready    (s_tready),
        .in_alive    (s_tdata[0]),
        .in_row      (row_count_reg),
        .in_col      (col_count_reg),
        .in_last_row (last_row),
        .in_last_col (last_col),
        .emit_free   (emit_free),
        .set_load    (set_load),
        .set_out     (set_bus)
    );

    lgs_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .set_load  (set_load),
        .set_in    (set_bus),
        .emit_free (emit_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    `LGS_ASSERT(a_col_in_grid, col_count_reg <= width_m1, "column counter beyond grid width")
    `LGS_ASSERT(a_row_in_grid, row_count_reg <= height_m1, "row counter beyond grid height")

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for life_generation_stream_core: one B3/S23 Life step per streamed grid.
// Checks each result against an in-bench Life predictor under random stalls on both sides.
// Depends on lgs_pkg and the life_generation_stream_core RTL.
`timescale 1ns / 1ps

module tb_top;
    import lgs_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int SETTLE_CYCLES = 10;
    localparam int HOLD_CYCLES = 400;
    localparam int ITEM_BUDGET = 310;
    localparam int MAX_FRAME_ITEMS = 40;
    // register indexes beyond the map; writes to these must be ignored
    localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED_LO = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED_HI = 2'd3;

    typedef struct packed {
        logic             next_alive;
        logic [ROW_W-1:0] out_row;
        logic [COL_W-1:0] out_col;
        logic             last;
    } gen_cell_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Life predictor state
    logic [GW_REG_W-1:0]   width_reg = GW_RESET;
    logic [GH_REG_W-1:0]   height_reg = GH_RESET;
    logic [MAX_WIDTH-1:0]  prev2_row = '0;
    logic [MAX_WIDTH-1:0]  prev1_row = '0;
    logic [MAX_WIDTH-1:0]  cur_row = '0;
    int                    at_row = 0;
    int                    at_col = 0;
    gen_cell_t             next_gen_q[$];

    logic                  cells_q[$];
    int                    cells_pushed = 0;
    int                    cells_taken = 0;
    logic                  cell_taken = 1'b0;
    int                    send_idle_pct = 33;
    int                    recv_idle_pct = 33;
    logic                  hold_arm = 1'b0;
    logic                  hold_done = 1'b0;
    int                    hold_left = 0;
    int                    err_cnt = 0;
    int                    cycles = 0;

    life_generation_stream_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    function automatic int eff_width();
        if (width_reg == 0) return 1;
        if (width_reg > MAX_WIDTH) return MAX_WIDTH;
        return int'(width_reg);
    endfunction

    function automatic int eff_height();
        if (height_reg == 0) return 1;
        if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
        return int'(height_reg);
    endfunction

    function automatic void restart_frame();
        prev2_row = '0;
        prev1_row = '0;
        cur_row = '0;
        at_row = 0;
        at_col = 0;
    endfunction

    // cells off either side of the grid are dead
    function automatic int cell_of(logic [MAX_WIDTH-1:0] row, int i, int w);
        if (i < 0 || i >= w) return 0;
        return int'(row[i]);
    endfunction

    function automatic gen_cell_t next_cell(int r, int c, logic [MAX_WIDTH-1:0] above,
                                            logic [MAX_WIDTH-1:0] mid,
                                            logic [MAX_WIDTH-1:0] below, int w);
        int        nbrs;
        gen_cell_t o;
        nbrs = 0;
        for (int d = -1; d <= 1; d++) begin
            nbrs += cell_of(above, c + d, w) + cell_of(below, c + d, w);
            if (d != 0) nbrs += cell_of(mid, c + d, w);
        end
        if (cell_of(mid, c, w) != 0) o.next_alive = (nbrs == 2 || nbrs == 3);
        else o.next_alive = (nbrs == 3);
        o.out_row = ROW_W'(r);
        o.out_col = COL_W'(c);
        o.last = 1'b0;
        return o;
    endfunction

    // Take one cell and queue every cell of the next generation it completes.
    function automatic void advance_grid(logic cell_bit);
        int                   w;
        int                   h;
        int                   r;
        int                   c;
        int                   n;
        logic                 last_row;
        logic                 last_col;
        logic [MAX_WIDTH-1:0] up2;
        logic [MAX_WIDTH-1:0] up1;
        gen_cell_t            res[4];
        w = eff_width();
        h = eff_height();
        r = at_row;
        c = at_col;
        n = 0;
        if (r >= h || c >= w) begin
            restart_frame();
            r = 0;
            c = 0;
        end
        last_row = (r == h - 1);
        last_col = (c == w - 1);
        if (c == 0) cur_row = '0;
        cur_row[c] = cell_bit;
        up2 = (r >= 2) ? prev2_row : '0;
        up1 = (r >= 1) ? prev1_row : '0;
        if (c >= 1) begin
            if (r >= 1) begin
                res[n] = next_cell(r - 1, c - 1, up2, up1, cur_row, w);
                n++;
            end
            if (last_row) begin
                res[n] = next_cell(r, c - 1, up1, cur_row, '0, w);
                n++;
            end
        end
        if (last_col) begin
            if (r >= 1) begin
                res[n] = next_cell(r - 1, c, up2, up1, cur_row, w);
                n++;
            end
            if (last_row) begin
                res[n] = next_cell(r, c, up1, cur_row, '0, w);
                n++;
            end
        end
        if (last_col && last_row && n > 0) res[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) next_gen_q.push_back(res[i]);
        if (last_col) begin
            if (last_row) begin
                restart_frame();
            end else begin
                prev2_row = prev1_row;
                prev1_row = cur_row;
                cur_row = '0;
                at_col = 0;
                at_row = r + 1;
            end
        end else begin
            at_col = c + 1;
        end
    endfunction

    // input side: accept, predict, watchdog
    always @(posedge aclk) begin
        cell_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            advance_grid(s_tdata[0]);
            cells_taken++;
        end
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("%0t: timeout, %0d of %0d items taken, %0d results pending", $time,
                     cells_taken, cells_pushed, next_gen_q.size());
            $display("tb_top: done, errors");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if (!s_tvalid || cell_taken) begin
            if (cells_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tdata <= S_TDATA_W'(cells_q.pop_front());
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_arm && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        gen_cell_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (next_gen_q.size() == 0) begin
                $display("%0t: result with none expected, tdata %h tlast %b", $time,
                         m_tdata, m_tlast);
                err_cnt++;
            end else begin
                want = next_gen_q.pop_front();
                if (m_tdata[0] !== want.next_alive) begin
                    $display("%0t: next_alive at (%0d,%0d) expected %b got %b", $time,
                             want.out_row, want.out_col, want.next_alive, m_tdata[0]);
                    err_cnt++;
                end
                if (m_tdata[ROW_W:1] !== want.out_row) begin
                    $display("%0t: out_row expected %0d got %0d", $time,
                             want.out_row, m_tdata[ROW_W:1]);
                    err_cnt++;
                end
                if (m_tdata[ROW_W+COL_W:ROW_W+1] !== want.out_col) begin
                    $display("%0t: out_col expected %0d got %0d", $time,
                             want.out_col, m_tdata[ROW_W+COL_W:ROW_W+1]);
                    err_cnt++;
                end
                if (m_tlast !== want.last) begin
                    $display("%0t: tlast at (%0d,%0d) expected %b got %b", $time,
                             want.out_row, want.out_col, want.last, m_tlast);
                    err_cnt++;
                end
            end
        end
    end

    // Write one register while idle; any mapped write restarts the frame.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (addr == REG_GRID_WIDTH) begin
            width_reg = data[GW_REG_W-1:0];
            restart_frame();
        end else if (addr == REG_GRID_HEIGHT) begin
            height_reg = data[GH_REG_W-1:0];
            restart_frame();
        end
    endtask

    task automatic feed_bits(input logic [31:0] bits, input int n);
        for (int i = 0; i < n; i++) cells_q.push_back(bits[i]);
        cells_pushed += n;
    endtask

    task automatic feed_random(input int n, input int density);
        for (int i = 0; i < n; i++) cells_q.push_back($urandom_range(99) < density);
        cells_pushed += n;
    endtask

    // Hold until every item is taken and every result has come, then pad.
    task automatic settle(input int extra);
        do @(negedge aclk);
        while (cells_taken != cells_pushed || next_gen_q.size() != 0);
        repeat (extra) @(negedge aclk);
    endtask

    initial begin
        int w;
        int h;
        int n;
        int ph;
        int density;
        logic [GW_REG_W-1:0] wsel;
        logic [GH_REG_W-1:0] hsel;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // single-cell grid: every cell dead next, every cell ends a frame
        write_reg(REG_GRID_WIDTH, 11'd1);
        write_reg(REG_GRID_HEIGHT, 11'd1);
        feed_bits(32'h1, 2);
        settle(SETTLE_CYCLES);

        // blinker on 3x3; a rewrite mid-frame must restart the frame
        write_reg(REG_GRID_WIDTH, 11'd3);
        write_reg(REG_GRID_HEIGHT, 11'd3);
        feed_bits(32'h2, 4);
        settle(SETTLE_CYCLES);
        write_reg(REG_GRID_HEIGHT, 11'd3);
        feed_bits(32'h92, 9);
        settle(SETTLE_CYCLES);

        // zero sizes act as one; upper data bits above the width field are dropped
        write_reg(REG_GRID_WIDTH, 11'h7C0);
        write_reg(REG_GRID_HEIGHT, 11'd0);
        feed_bits(32'h3, 2);
        settle(SETTLE_CYCLES);

        // 2x2 block; unmapped writes mid-frame must leave the frame alone
        write_reg(REG_GRID_WIDTH, 11'd2);
        write_reg(REG_GRID_HEIGHT, 11'd2);
        feed_bits(32'h3, 2);
        settle(SETTLE_CYCLES);
        write_reg(REG_UNMAPPED_LO, CFG_DATA_W'($urandom));
        write_reg(REG_UNMAPPED_HI, CFG_DATA_W'($urandom));
        feed_bits(32'h3, 2);
        settle(SETTLE_CYCLES);

        // oversize width and height clamp to the maximum
        write_reg(REG_GRID_WIDTH, 11'd63);
        write_reg(REG_GRID_HEIGHT, 11'd2047);
        feed_bits(32'h15, 5);
        settle(SETTLE_CYCLES);

        ph = 0;
        while (ph < 6 || cells_pushed < ITEM_BUDGET) begin
            send_idle_pct = (ph == 4) ? 0 : 33;
            recv_idle_pct = (ph == 4) ? 0 : 33;
            density = ($urandom_range(3) == 0) ? $urandom_range(10, 90) : 45;
            if (ph == 2) begin
                // full-width frame behind a long receiver hold-off
                write_reg(REG_GRID_WIDTH, 11'd32);
                write_reg(REG_GRID_HEIGHT, CFG_DATA_W'($urandom_range(2, 3)));
                hold_arm = 1'b1;
                n = eff_width() * eff_height();
            end else begin
                case ($urandom_range(9))
                    0: wsel = '0;
                    1: wsel = GW_REG_W'($urandom_range(33, 63));
                    2: wsel = GW_REG_W'(MAX_WIDTH);
                    default: wsel = GW_REG_W'($urandom_range(1, 8));
                endcase
                case ($urandom_range(9))
                    0: hsel = '0;
                    1: hsel = GH_REG_W'($urandom_range(1025, 2047));
                    2: hsel = GH_REG_W'(MAX_HEIGHT);
                    default: hsel = GH_REG_W'($urandom_range(1, 8));
                endcase
                if ($urandom_range(3) != 0)
                    write_reg(REG_GRID_WIDTH, {5'($urandom), wsel});
                if ($urandom_range(3) != 0)
                    write_reg(REG_GRID_HEIGHT, hsel);
                w = eff_width();
                h = eff_height();
                if (w * h <= 64) begin
                    n = w * h * $urandom_range(1, 3);
                    if ($urandom_range(1) == 1) n += $urandom_range(0, w * h - 1);
                end else begin
                    n = w * $urandom_range(1, 3);
                end
                // keep the total near the item budget
                if (n > MAX_FRAME_ITEMS) n = MAX_FRAME_ITEMS;
                if (ph >= 6 && n > ITEM_BUDGET - cells_pushed) n = ITEM_BUDGET - cells_pushed;
            end
            if (ph == 5) begin
                // sender pauses mid-frame until the block has drained
                feed_random(n / 2, density);
                settle(0);
                feed_random(n - n / 2, density);
            end else begin
                feed_random(n, density);
            end
            settle(SETTLE_CYCLES);
            ph++;
        end

        settle(2 * SETTLE_CYCLES);
        if (err_cnt == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
